// File: sv/b64e_pkg.sv
package b64e_pkg;

	// Default number of entries in the request queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// ASCII code of the padding character.
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// ASCII anchors of the alphabet ranges.
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_SLASH   = 8'h2F;

	// Lowest and highest ASCII codes the block can ever send.
	localparam logic [7:0] CHAR_MIN = 8'h2B;
	localparam logic [7:0] CHAR_MAX = 8'h7A;

	// Position within the current 3-byte group.
	typedef enum logic [2:0] {
		PH_0 = 3'b001,
		PH_1 = 3'b010,
		PH_2 = 3'b100
	} phase_t;

	// One output character: either a 6-bit code or a padding mark.
	typedef struct packed {
		logic       pad;
		logic [5:0] six;
	} slot_t;

	// Work for the back end: up to four characters produced by one byte.
	typedef struct packed {
		slot_t [3:0] slots;
		logic  [1:0] cnt_m1;
		logic        last;
	} job_t;

	// Maps a 6-bit code to its character of the standard alphabet.
	function automatic logic [7:0] enc_char(input logic [5:0] six);
		logic [7:0] wide;
		wide = {2'b00, six};
		if (six < 6'd26) begin
			return CHAR_UPPER_A + wide;
		end else if (six < 6'd52) begin
			return CHAR_LOWER_A + wide - 8'd26;
		end else if (six < 6'd62) begin
			return CHAR_DIGIT_0 + wide - 8'd52;
		end else if (six == 6'd62) begin
			return CHAR_PLUS;
		end else begin
			return CHAR_SLASH;
		end
	endfunction

endpackage

// File: sv/b64e_front.sv
module b64e_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	input  logic          q_full,
	output logic          in_ready,
	output logic          push,
	output b64e_pkg::job_t push_job
);
	import b64e_pkg::*;

	phase_t     phase_q;
	logic [3:0] carry_q;
	phase_t     phase_nx;
	logic [3:0] carry_nx;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	// Split the byte into the characters it completes and the bits it leaves.
	always_comb begin
		push_job = '0;
		phase_nx = PH_0;
		carry_nx = '0;
		unique case (phase_q)
			PH_1: begin
				push_job.slots[0].six = {carry_q[1:0], in_byte[7:4]};
				if (in_last) begin
					push_job.slots[1].six = {in_byte[3:0], 2'b00};
					push_job.slots[2].pad = 1'b1;
					push_job.cnt_m1       = 2'd2;
					push_job.last         = 1'b1;
				end else begin
					carry_nx = in_byte[3:0];
					phase_nx = PH_2;
				end
			end
			PH_2: begin
				push_job.slots[0].six = {carry_q, in_byte[7:6]};
				push_job.slots[1].six = in_byte[5:0];
				push_job.cnt_m1       = 2'd1;
				push_job.last         = in_last;
			end
			default: begin
				// An unknown phase is treated as the start of a group.
				push_job.slots[0].six = in_byte[7:2];
				if (in_last) begin
					push_job.slots[1].six = {in_byte[1:0], 4'b0000};
					push_job.slots[2].pad = 1'b1;
					push_job.slots[3].pad = 1'b1;
					push_job.cnt_m1       = 2'd3;
					push_job.last         = 1'b1;
				end else begin
					carry_nx = {2'b00, in_byte[1:0]};
					phase_nx = PH_1;
				end
			end
		endcase
	end

	// Group state advances on every accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_0;
			carry_q <= '0;
		end else if (push) begin
			phase_q <= phase_nx;
			carry_q <= carry_nx;
		end
	end

endmodule

// File: sv/b64e_queue.sv
module b64e_queue #(
	parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  b64e_pkg::job_t               push_job,
	input  logic                         pop,
	output b64e_pkg::job_t               head,
	output logic                         empty,
	output logic                         full,
	output logic [$clog2(DEPTH+1)-1:0]   level
);
	import b64e_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign level   = cnt_q;
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Storage entries are written at the write pointer.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers wrap at the last entry; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: sv/b64e_back.sv
module b64e_back (
	input  logic           clk,
	input  logic           arst_n,
	input  b64e_pkg::job_t head,
	input  logic           empty,
	input  logic           out_ready,
	output logic           pop,
	output logic           out_valid,
	output logic [7:0]     out_char,
	output logic           out_last
);
	import b64e_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       out_free;
	logic       emit;
	slot_t      cur;

	assign out_free  = !valid_q || out_ready;
	assign emit      = out_free && !empty;
	assign cur       = head.slots[idx_q];
	assign pop       = emit && (idx_q == head.cnt_m1);
	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

	// Character index within the request at the head of the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (emit) begin
				idx_q <= pop ? 2'd0 : idx_q + 2'd1;
			end
			if (out_free) begin
				valid_q <= !empty;
			end
		end
	end

	// Output register holds one character until the receiver takes it.
	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= cur.pad ? PAD_CHAR : enc_char(cur.six);
			last_q <= head.last && pop;
		end
	end

endmodule

// File: sv/base64_stream_encoder.sv
// Streaming Base64 encoder with the standard alphabet and '=' padding.
// Input channel s_axis: one raw byte per request in tdata, with tlast
// marking the final byte of a message. Output channel m_axis: one ASCII
// character per request in tdata, with tlast on the final character of
// the encoded message.
// A front stage tracks the position in the 3-byte group and turns each
// byte into a request of one to four characters; a queue of QueueDepth
// requests decouples it from the back stage, which sends one character
// per cycle, while the receiver is ready, from a registered output.
// The first character of a byte is written into the queue and then into
// the output register before it is valid. Throughput: one character per
// cycle while the receiver is ready; a byte with tlast yields up to four
// characters for the back stage. The input accepts a byte every cycle while
// the queue has room.
// When the receiver stalls, the output register holds its character, the
// queue fills, and only then is s_axis_tready dropped.
// Reset clears the group position, the queue and the output valid; the
// block is ready for a new message as soon as reset is released.
module base64_stream_encoder #(
	parameter int QueueDepth = b64e_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_char
	output logic       m_axis_tlast
);
	import b64e_pkg::*;

	localparam int CNT_W = $clog2(QueueDepth + 1);

	job_t             push_job;
	job_t             head;
	logic             push;
	logic             pop;
	logic             q_empty;
	logic             q_full;
	logic [CNT_W-1:0] q_level;

	// Byte intake and group tracking.
	b64e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.q_full   (q_full),
		.in_ready (s_axis_tready),
		.push     (push),
		.push_job (push_job)
	);

	// Request queue between the two halves.
	b64e_queue #(
		.DEPTH (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full),
		.level    (q_level)
	);

	// Character output.
	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.out_ready (m_axis_tready),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_char  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

	// Queue occupancy never exceeds its depth.
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= CNT_W'(QueueDepth))
		else $error("request queue overfilled");

	// A push without a pop grows the queue by exactly one.
	a_level_grow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> q_level == $past(q_level) + CNT_W'(1))
		else $error("request queue count slipped");

	// Every character sent lies in the printable Base64 range.
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata >= CHAR_MIN) && (m_axis_tdata <= CHAR_MAX))
		else $error("character outside the alphabet");

	// Back stage only pops while the queue holds a request.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("pop from empty request queue");

endmodule
